FILE: hdl/lel_pkg.sv
// ----------------------------------------------------------------------------
// lel_pkg
// Types, codes and character-class helpers for the expression lexer.
// ----------------------------------------------------------------------------
package lel_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_STRQ, M_NUM, M_NUMDOT, M_WORD, M_WORDDOT,
    M_BANG, M_LESS, M_GREATER, M_DRAIN
  } mode_e;

  typedef enum logic [3:0] {
    K_STR, K_NUM, K_IDENT, K_KW, K_LP, K_RP, K_COMMA, K_STAR, K_CMP,
    K_END, K_ERR
  } kind_e;

  localparam logic [3:0] KW_NONE = 4'd0;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LE = 3'd2;
  localparam logic [2:0] CMP_LG = 3'd3;
  localparam logic [2:0] CMP_LT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;
  localparam logic [2:0] CMP_GT = 3'd6;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_UNEXP  = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LP     = 8'h28;
  localparam logic [7:0] CH_RP     = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [15:0] CNT_MAX  = 16'hFFFF;
  localparam int          KW_COUNT = 11;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  kw;
    logic [2:0]  cmp;
    logic [15:0] start;
    logic [15:0] raw;
    logic [15:0] val;
    logic [1:0]  ek;
    logic [7:0]  ec;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [47:0] prefix;
    logic [15:0] cnt;
  } word_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [47:0] text;
  } kw_ent_t;

  localparam kw_ent_t KW_TABLE [KW_COUNT] = '{
    '{3'd3, 48'h000000414E44},  // AND
    '{3'd2, 48'h000000004F52},  // OR
    '{3'd3, 48'h0000004E4F54},  // NOT
    '{3'd2, 48'h00000000494E},  // IN
    '{3'd6, 48'h455849535453},  // EXISTS
    '{3'd6, 48'h53454C454354},  // SELECT
    '{3'd3, 48'h000000414E59},  // ANY
    '{3'd3, 48'h000000414C4C},  // ALL
    '{3'd2, 48'h000000004953},  // IS
    '{3'd4, 48'h00004C494B45},  // LIKE
    '{3'd4, 48'h00004E554C4C}   // NULL
  };

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D], 8'h85, 8'hA0};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'hAA, 8'hB5, 8'hBA}) ||
           (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return is_letter(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER ||
           (c inside {8'hB2, 8'hB3, 8'hB9, [8'hBC:8'hBE]});
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sat16(logic [31:0] v);
    return (v > 32'(CNT_MAX)) ? CNT_MAX : v[15:0];
  endfunction

  function automatic word_t word_push(word_t w, logic [7:0] c);
    word_t      o;
    logic [7:0] u;
    o = w;
    u = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
    if (w.cnt < 16'd6) o.prefix = {w.prefix[39:0], u};
    o.cnt = sat_inc16(w.cnt);
    return o;
  endfunction

  function automatic logic [3:0] kw_lookup(word_t w, logic has_dot);
    logic [3:0] k;
    k = KW_NONE;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!has_dot && w.cnt == 16'(KW_TABLE[i].len) && w.prefix == KW_TABLE[i].text) begin
        k = 4'(i + 1);
      end
    end
    return k;
  endfunction

  function automatic res_t mk_res(kind_e kind, logic [3:0] kw, logic [2:0] cmp,
                                  logic [31:0] start, logic [31:0] raw,
                                  logic [15:0] val, logic [1:0] ek,
                                  logic [7:0] ec, logic last);
    res_t r;
    r.kind  = kind;
    r.kw    = kw;
    r.cmp   = cmp;
    r.start = start[15:0];
    r.raw   = sat16(raw);
    r.val   = val;
    r.ek    = ek;
    r.ec    = ec;
    r.last  = last;
    return r;
  endfunction

endpackage

FILE: hdl/lel_core.sv
// ----------------------------------------------------------------------------
// lel_core
// Input register, lexer state and the per-character step logic.
// ----------------------------------------------------------------------------
module lel_core import lel_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        end_of_text_i,
  input  logic        room_i,
  output push_t       push_o
);

  localparam int PB = POSITION_BITS;

  logic          in_vld_q;
  logic [7:0]    chr_q;
  logic          eot_q;
  logic          fire;

  mode_e         mode_q, mode_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] tstart_q, tstart_d;
  logic [PB-1:0] dotpos;
  logic [15:0]   cnt_q, cnt_d;
  logic          dot_q, dot_d;
  logic [47:0]   prefix_q, prefix_d;
  logic          hdot_q, hdot_d;

  mode_e         ic_mode;
  logic          ic_v;
  res_t          ic_r;

  logic          pre_v, post_v, take_idle;
  res_t          pre_r, post_r;

  function automatic logic [31:0] span(logic [PB-1:0] e, logic [PB-1:0] s);
    return (e >= s) ? 32'(e - s) : 32'd0;
  endfunction

  assign fire       = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign dotpos     = (pos_q != '0) ? pos_q - 1'b1 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      chr_q <= character_i;
      eot_q <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      tstart_q <= '0;
      cnt_q    <= '0;
      dot_q    <= 1'b0;
      prefix_q <= '0;
      hdot_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      cnt_q    <= cnt_d;
      dot_q    <= dot_d;
      prefix_q <= prefix_d;
      hdot_q   <= hdot_d;
    end
  end

  // start of a new token with nothing pending
  always_comb begin
    ic_mode = M_IDLE;
    ic_v    = 1'b0;
    ic_r    = mk_res(K_ERR, KW_NONE, CMP_EQ, 32'(pos_q), 32'd0, 16'd0, ERR_UNEXP, chr_q, 1'b1);
    if (is_space(chr_q)) begin
      ic_mode = M_IDLE;
    end else if (chr_q == CH_QUOTE) begin
      ic_mode = M_STR;
    end else if (is_digit(chr_q)) begin
      ic_mode = M_NUM;
    end else if (is_ident_start(chr_q)) begin
      ic_mode = M_WORD;
    end else begin
      case (chr_q)
        CH_LP: begin
          ic_v = 1'b1;
          ic_r = mk_res(K_LP, KW_NONE, CMP_EQ, 32'(pos_q), 32'd1, 16'd0, ERR_NONE, 8'd0, 1'b0);
        end
        CH_RP: begin
          ic_v = 1'b1;
          ic_r = mk_res(K_RP, KW_NONE, CMP_EQ, 32'(pos_q), 32'd1, 16'd0, ERR_NONE, 8'd0, 1'b0);
        end
        CH_COMMA: begin
          ic_v = 1'b1;
          ic_r = mk_res(K_COMMA, KW_NONE, CMP_EQ, 32'(pos_q), 32'd1, 16'd0, ERR_NONE, 8'd0,
                        1'b0);
        end
        CH_STAR: begin
          ic_v = 1'b1;
          ic_r = mk_res(K_STAR, KW_NONE, CMP_EQ, 32'(pos_q), 32'd1, 16'd0, ERR_NONE, 8'd0,
                        1'b0);
        end
        CH_EQ: begin
          ic_v = 1'b1;
          ic_r = mk_res(K_CMP, KW_NONE, CMP_EQ, 32'(pos_q), 32'd1, 16'd0, ERR_NONE, 8'd0,
                        1'b0);
        end
        CH_BANG: ic_mode = M_BANG;
        CH_LT:   ic_mode = M_LESS;
        CH_GT:   ic_mode = M_GREATER;
        default: begin
          ic_v    = 1'b1;
          ic_mode = M_DRAIN;
        end
      endcase
    end
  end

  always_comb begin
    word_t w;
    word_t cur;
    res_t  wtok_pos;
    res_t  wtok_dot;
    res_t  end_tok;
    res_t  dot_err;
    logic [3:0] kw;

    cur      = '{prefix: prefix_q, cnt: cnt_q};
    kw       = kw_lookup(cur, hdot_q);
    wtok_pos = mk_res((kw != KW_NONE) ? K_KW : K_IDENT, kw, CMP_EQ, 32'(tstart_q),
                      span(pos_q, tstart_q), 16'd0, ERR_NONE, 8'd0, 1'b0);
    wtok_dot = mk_res((kw != KW_NONE) ? K_KW : K_IDENT, kw, CMP_EQ, 32'(tstart_q),
                      span(dotpos, tstart_q), 16'd0, ERR_NONE, 8'd0, 1'b0);
    end_tok  = mk_res(K_END, KW_NONE, CMP_EQ, 32'(pos_q), 32'd0, 16'd0, ERR_NONE, 8'd0, 1'b1);
    dot_err  = mk_res(K_ERR, KW_NONE, CMP_EQ, 32'(dotpos), 32'd0, 16'd0, ERR_UNEXP, CH_DOT,
                      1'b1);
    w        = cur;

    mode_d    = mode_q;
    pos_d     = pos_q;
    tstart_d  = tstart_q;
    cnt_d     = cnt_q;
    dot_d     = dot_q;
    prefix_d  = prefix_q;
    hdot_d    = hdot_q;
    pre_v     = 1'b0;
    pre_r     = end_tok;
    post_v    = 1'b0;
    post_r    = end_tok;
    take_idle = 1'b0;

    if (fire && eot_q) begin
      post_v = 1'b1;
      case (mode_q)
        M_STR: begin
          post_r = mk_res(K_ERR, KW_NONE, CMP_EQ, 32'(tstart_q), 32'd0, 16'd0, ERR_UNTERM,
                          8'd0, 1'b1);
        end
        M_STRQ: begin
          pre_v = 1'b1;
          pre_r = mk_res(K_STR, KW_NONE, CMP_EQ, 32'(tstart_q), span(pos_q, tstart_q), cnt_q,
                         ERR_NONE, 8'd0, 1'b0);
        end
        M_NUM: begin
          pre_v = 1'b1;
          pre_r = mk_res(K_NUM, KW_NONE, CMP_EQ, 32'(tstart_q), span(pos_q, tstart_q), 16'd0,
                         ERR_NONE, 8'd0, 1'b0);
        end
        M_WORD: begin
          pre_v = 1'b1;
          pre_r = wtok_pos;
        end
        M_NUMDOT: begin
          pre_v  = 1'b1;
          pre_r  = mk_res(K_NUM, KW_NONE, CMP_EQ, 32'(tstart_q), span(dotpos, tstart_q),
                          16'd0, ERR_NONE, 8'd0, 1'b0);
          post_r = dot_err;
        end
        M_WORDDOT: begin
          pre_v  = 1'b1;
          pre_r  = wtok_dot;
          post_r = dot_err;
        end
        M_BANG: begin
          post_r = mk_res(K_ERR, KW_NONE, CMP_EQ, 32'(tstart_q), 32'd0, 16'd0, ERR_UNEXP,
                          CH_BANG, 1'b1);
        end
        M_LESS: begin
          pre_v = 1'b1;
          pre_r = mk_res(K_CMP, KW_NONE, CMP_LT, 32'(tstart_q), 32'd1, 16'd0, ERR_NONE, 8'd0,
                         1'b0);
        end
        M_GREATER: begin
          pre_v = 1'b1;
          pre_r = mk_res(K_CMP, KW_NONE, CMP_GT, 32'(tstart_q), 32'd1, 16'd0, ERR_NONE, 8'd0,
                         1'b0);
        end
        M_DRAIN: post_v = 1'b0;
        default: post_r = end_tok;
      endcase
      mode_d   = M_IDLE;
      pos_d    = '0;
      tstart_d = '0;
      cnt_d    = '0;
      dot_d    = 1'b0;
      prefix_d = '0;
      hdot_d   = 1'b0;
    end else if (fire) begin
      case (mode_q)
        M_DRAIN: mode_d = M_DRAIN;
        M_STR: begin
          if (chr_q == CH_QUOTE) mode_d = M_STRQ;
          else cnt_d = sat_inc16(cnt_q);
        end
        M_STRQ: begin
          if (chr_q == CH_QUOTE) begin
            cnt_d  = sat_inc16(cnt_q);
            mode_d = M_STR;
          end else begin
            pre_v     = 1'b1;
            pre_r     = mk_res(K_STR, KW_NONE, CMP_EQ, 32'(tstart_q), span(pos_q, tstart_q),
                               cnt_q, ERR_NONE, 8'd0, 1'b0);
            take_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(chr_q)) begin
            mode_d = M_NUM;
          end else if (chr_q == CH_DOT && !dot_q) begin
            mode_d = M_NUMDOT;
          end else begin
            pre_v     = 1'b1;
            pre_r     = mk_res(K_NUM, KW_NONE, CMP_EQ, 32'(tstart_q), span(pos_q, tstart_q),
                               16'd0, ERR_NONE, 8'd0, 1'b0);
            take_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(chr_q)) begin
            dot_d  = 1'b1;
            mode_d = M_NUM;
          end else begin
            pre_v  = 1'b1;
            pre_r  = mk_res(K_NUM, KW_NONE, CMP_EQ, 32'(tstart_q), span(dotpos, tstart_q),
                            16'd0, ERR_NONE, 8'd0, 1'b0);
            post_v = 1'b1;
            post_r = dot_err;
            mode_d = M_DRAIN;
          end
        end
        M_WORD: begin
          if (is_ident_char(chr_q)) begin
            w        = word_push(cur, chr_q);
            prefix_d = w.prefix;
            cnt_d    = w.cnt;
          end else if (chr_q == CH_DOT) begin
            mode_d = M_WORDDOT;
          end else begin
            pre_v     = 1'b1;
            pre_r     = wtok_pos;
            take_idle = 1'b1;
          end
        end
        M_WORDDOT: begin
          if (is_ident_char(chr_q)) begin
            w        = word_push(word_push(cur, CH_DOT), chr_q);
            prefix_d = w.prefix;
            cnt_d    = w.cnt;
            hdot_d   = 1'b1;
            mode_d   = M_WORD;
          end else begin
            pre_v  = 1'b1;
            pre_r  = wtok_dot;
            post_v = 1'b1;
            post_r = dot_err;
            mode_d = M_DRAIN;
          end
        end
        M_BANG: begin
          if (chr_q == CH_EQ) begin
            pre_v  = 1'b1;
            pre_r  = mk_res(K_CMP, KW_NONE, CMP_NE, 32'(tstart_q), 32'd2, 16'd0, ERR_NONE,
                            8'd0, 1'b0);
            mode_d = M_IDLE;
          end else begin
            post_v = 1'b1;
            post_r = mk_res(K_ERR, KW_NONE, CMP_EQ, 32'(tstart_q), 32'd0, 16'd0, ERR_UNEXP,
                            CH_BANG, 1'b1);
            mode_d = M_DRAIN;
          end
        end
        M_LESS: begin
          pre_v = 1'b1;
          if (chr_q == CH_EQ || chr_q == CH_GT) begin
            pre_r  = mk_res(K_CMP, KW_NONE, (chr_q == CH_EQ) ? CMP_LE : CMP_LG,
                            32'(tstart_q), 32'd2, 16'd0, ERR_NONE, 8'd0, 1'b0);
            mode_d = M_IDLE;
          end else begin
            pre_r     = mk_res(K_CMP, KW_NONE, CMP_LT, 32'(tstart_q), 32'd1, 16'd0, ERR_NONE,
                               8'd0, 1'b0);
            take_idle = 1'b1;
          end
        end
        M_GREATER: begin
          pre_v = 1'b1;
          if (chr_q == CH_EQ) begin
            pre_r  = mk_res(K_CMP, KW_NONE, CMP_GE, 32'(tstart_q), 32'd2, 16'd0, ERR_NONE,
                            8'd0, 1'b0);
            mode_d = M_IDLE;
          end else begin
            pre_r     = mk_res(K_CMP, KW_NONE, CMP_GT, 32'(tstart_q), 32'd1, 16'd0, ERR_NONE,
                               8'd0, 1'b0);
            take_idle = 1'b1;
          end
        end
        default: take_idle = 1'b1;
      endcase

      if (take_idle) begin
        tstart_d = pos_q;
        mode_d   = ic_mode;
        post_v   = ic_v;
        post_r   = ic_r;
        case (ic_mode)
          M_STR: cnt_d = '0;
          M_NUM: dot_d = 1'b0;
          M_WORD: begin
            w        = word_push('0, chr_q);
            prefix_d = w.prefix;
            cnt_d    = w.cnt;
            hdot_d   = 1'b0;
          end
          default: cnt_d = cnt_q;
        endcase
      end

      if (mode_d != M_DRAIN) begin
        pos_d = (pos_q == {PB{1'b1}}) ? pos_q : pos_q + 1'b1;
      end
    end
  end

  assign push_o.n  = {1'b0, pre_v} + {1'b0, post_v};
  assign push_o.r0 = pre_v ? pre_r : post_r;
  assign push_o.r1 = post_r;

endmodule

FILE: hdl/lel_res_fifo.sv
// ----------------------------------------------------------------------------
// lel_res_fifo
// Four-entry token queue; takes up to two words per cycle, gives one while not stalled.
// ----------------------------------------------------------------------------
module lel_res_fifo import lel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       room_o,
  output logic [2:0] level_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       head_o
);

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] lvl_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (lvl_q != 3'd0);
  assign room_o      = (lvl_q <= 3'd2);
  assign level_o     = lvl_q;
  assign head_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + {1'b0, pop};
      lvl_q <= lvl_q + {1'b0, push_i.n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

endmodule

FILE: hdl/logic_expression_lexer.sv
// ----------------------------------------------------------------------------
// logic_expression_lexer
// Streaming expression lexer: one character in, token descriptors out.
// ----------------------------------------------------------------------------
// Takes one character (or an end marker) per cycle, unless stalled, and
// returns token words through a four-entry queue. A character is registered,
// then classified and folded into the lexer state; the words it completes are
// written into the queue, whose head drives the outputs. Input rate is one
// character per cycle as long as the characters produce on average no more
// than one word each; a character that both closes a pending token and forms
// or fails another (for example ")" after a name, or the end marker) yields
// two words, which the queue drains one per cycle while the output is not
// stalled, and input stalls while the queue holds more than two words.
// ----------------------------------------------------------------------------
module logic_expression_lexer import lel_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [3:0]  keyword_code_o,
  output logic [2:0]  compare_code_o,
  output logic [15:0] start_position_o,
  output logic [15:0] raw_length_o,
  output logic [15:0] value_length_o,
  output logic [1:0]  error_kind_o,
  output logic [7:0]  error_character_o,
  output logic        last_token_o
);

  push_t      push;
  logic       room;
  logic [2:0] level;
  res_t       head;

  lel_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .character_i  (character_i),
    .end_of_text_i(end_of_text_i),
    .room_i       (room),
    .push_o       (push)
  );

  lel_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .level_o    (level),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign token_kind_o      = head.kind;
  assign keyword_code_o    = head.kw;
  assign compare_code_o    = head.cmp;
  assign start_position_o  = head.start;
  assign raw_length_o      = head.raw;
  assign value_length_o    = head.val;
  assign error_kind_o      = head.ek;
  assign error_character_o = head.ec;
  assign last_token_o      = head.last;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= 3'd4)
    else $error("token queue overflow");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> level >= 3'd3)
    else $error("input stalled with queue room");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_token_o |-> head.kind == K_END || head.kind == K_ERR)
    else $error("last word is neither end nor error");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && head.kind == K_ERR |-> last_token_o && head.ek != ERR_NONE)
    else $error("error word not marked last");

endmodule
